>>> hdl/hbdma_pkg.sv
// ----------------------------------------------------------------------------
// hbdma_pkg
// Shared types and constants for the hblank block DMA controller.
// ----------------------------------------------------------------------------
package hbdma_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam logic [4:0] BLOCK_LOAD = 5'(BLOCK_BYTES % 32);

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_HBLANK = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [15:0] ADDR_SRC_HI = 16'hFF51;
  localparam logic [15:0] ADDR_SRC_LO = 16'hFF52;
  localparam logic [15:0] ADDR_DST_HI = 16'hFF53;
  localparam logic [15:0] ADDR_DST_LO = 16'hFF54;
  localparam logic [15:0] ADDR_CTRL   = 16'hFF55;

  localparam logic [6:0] BLOCKS_DONE = 7'h7F;
  localparam logic [7:0] READ_OPEN   = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] reg_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic        transfer_active;
    logic        bad_register;
  } rsp_t;

  typedef struct packed {
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic [4:0]  bytes_left;
    logic [6:0]  blocks_remaining;
    logic        line_paced;
    logic        moving;
    logic        enabled;
  } state_t;

endpackage

>>> hdl/hbdma_step.sv
// ----------------------------------------------------------------------------
// hbdma_step
// Next-state and result logic for one transaction of the DMA controller.
// ----------------------------------------------------------------------------
module hbdma_step (
  input  hbdma_pkg::state_t st,
  input  hbdma_pkg::req_t   req,
  output hbdma_pkg::state_t st_next,
  output hbdma_pkg::rsp_t   rsp
);

  logic       want_hblank;
  logic [4:0] bytes_dec;

  assign want_hblank = req.write_data[7];
  assign bytes_dec   = st.bytes_left - 5'd1;

  always_comb begin
    st_next = st;
    rsp     = '0;
    unique case (req.op)
      hbdma_pkg::OP_WRITE: begin
        unique case (req.reg_address)
          hbdma_pkg::ADDR_SRC_HI: begin
            st_next.source_address = {req.write_data, st.source_address[7:0]};
          end
          hbdma_pkg::ADDR_SRC_LO: begin
            st_next.source_address = {st.source_address[15:8], req.write_data[7:4], 4'h0};
          end
          hbdma_pkg::ADDR_DST_HI: begin
            st_next.dest_address = {3'b100, req.write_data[4:0], st.dest_address[7:0]};
          end
          hbdma_pkg::ADDR_DST_LO: begin
            st_next.dest_address = {st.dest_address[15:8], req.write_data[7:4], 4'h0};
          end
          hbdma_pkg::ADDR_CTRL: begin
            if (st.enabled && st.line_paced && !want_hblank) begin
              // cancel a running hblank transfer
              st_next.line_paced = 1'b0;
              st_next.enabled    = 1'b0;
              st_next.moving     = 1'b0;
            end else begin
              st_next.line_paced       = want_hblank;
              st_next.blocks_remaining = req.write_data[6:0];
              st_next.bytes_left       = hbdma_pkg::BLOCK_LOAD;
              st_next.enabled          = 1'b1;
              if (!want_hblank) begin
                st_next.moving = 1'b1;
              end
            end
          end
          default: begin
            rsp.bad_register = 1'b1;
          end
        endcase
      end
      hbdma_pkg::OP_READ: begin
        if (req.reg_address == hbdma_pkg::ADDR_CTRL) begin
          rsp.read_data = {!st.enabled, st.blocks_remaining};
        end else begin
          rsp.read_data = hbdma_pkg::READ_OPEN;
        end
      end
      hbdma_pkg::OP_HBLANK: begin
        if (st.enabled && st.line_paced) begin
          st_next.moving = 1'b1;
        end
      end
      hbdma_pkg::OP_TICK: begin
        if (st.enabled && st.moving) begin
          rsp.copy_valid         = 1'b1;
          rsp.copy_source        = st.source_address;
          rsp.copy_dest          = {3'b100, st.dest_address[12:0]};
          st_next.source_address = st.source_address + 16'd1;
          st_next.dest_address   = st.dest_address + 16'd1;
          st_next.bytes_left     = bytes_dec;
          if (bytes_dec == 5'd0) begin
            st_next.bytes_left = hbdma_pkg::BLOCK_LOAD;
            if (st.blocks_remaining == 7'd0) begin
              st_next.blocks_remaining = hbdma_pkg::BLOCKS_DONE;
              st_next.enabled          = 1'b0;
              st_next.moving           = 1'b0;
            end else begin
              st_next.blocks_remaining = st.blocks_remaining - 7'd1;
              if (st.line_paced) begin
                st_next.moving = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase
    rsp.transfer_active = st_next.moving;
  end

endmodule

>>> hdl/hblank_block_dma_controller.sv
// ----------------------------------------------------------------------------
// hblank_block_dma_controller
// Video-memory block DMA controller: register access, hblank events and
// byte ticks in, one result with an optional byte-copy request out.
//
//   channel | signals                    | direction
//   --------+----------------------------+----------
//   request | req_valid, req_ready, req  | in
//   result  | rsp_valid, rsp_ready, rsp  | out
//
// One transaction per cycle while req_ready is high; each result appears in the cycle after accept.
// The only holding point is the result register: req_ready is high when it
// is empty or being taken this cycle.
// rst is synchronous and clears all controller state and rsp_valid.
// ----------------------------------------------------------------------------
module hblank_block_dma_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hbdma_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hbdma_pkg::rsp_t   rsp
);

  hbdma_pkg::state_t st;
  hbdma_pkg::state_t st_next;
  hbdma_pkg::rsp_t   rsp_next;
  logic              accept;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  hbdma_step u_step (
    .st      (st),
    .req     (req),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_moving_needs_enable: assert property (@(posedge clk) disable iff (rst)
    st.moving |-> st.enabled)
    else $error("moving while not enabled");

  a_block_count_live: assert property (@(posedge clk) disable iff (rst)
    st.enabled |-> st.bytes_left != 5'd0)
    else $error("enabled with empty block counter");

  a_dest_window: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.copy_valid |-> rsp.copy_dest[15:13] == 3'b100)
    else $error("copy destination outside video memory");

  a_active_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.transfer_active == st.moving)
    else $error("transfer_active disagrees with state");

  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bad_register |-> !rsp.copy_valid && rsp.read_data == 8'h00)
    else $error("bad write produced data");
`endif

endmodule
